// ===== rtl/core/kmp_pkg.sv =====
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared widths, request and status codes, and beat and memory port types
// for the streaming string matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package kmp_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int COUNT_WIDTH = 32;
    localparam int SYM_W       = 8;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int CNT_OUT_W   = 32;
    localparam int LEN_OUT_W   = 7;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_TEXT   = 2'd2,
        REQ_NOP    = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_WALK = 1'b1
    } t_state;

    typedef struct packed {
        t_req_type          req_type;
        logic [SYM_W-1:0]   symbol;
    } t_req;

    typedef struct packed {
        logic                 match_found;
        logic [CNT_OUT_W-1:0] match_count;
        logic [LEN_OUT_W-1:0] pattern_length;
        t_status              status;
    } t_res;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [SYM_W-1:0]   wpat;
        logic [LEN_W-1:0]   wfail;
        logic [IDX_W-1:0]   raddr_pat;
        logic [IDX_W-1:0]   raddr_fail;
    } t_mem_req;

endpackage

`default_nettype wire

// ===== rtl/core/kmp_ram.sv =====
// ----------------------------------------------------------------------------
// kmp_ram
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/kmp_engine.sv =====
// ----------------------------------------------------------------------------
// kmp_engine
// Request sequencer: decodes each beat, walks failure links through the
// pattern and failure memories, and updates length, prefix, position and count.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_engine
    import kmp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire t_req             i_req,
    input  wire logic [SYM_W-1:0] i_rd_pat,
    input  wire logic [LEN_W-1:0] i_rd_fail,
    output logic                  o_busy,
    output logic                  o_done,
    output t_res                  o_res,
    output t_mem_req              o_mem
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    t_state                 r_state, n_state;
    logic [LEN_W-1:0]       r_len, n_len;
    logic [LEN_W-1:0]       r_bpl, n_bpl;
    logic [LEN_W-1:0]       r_pos, n_pos;
    logic [COUNT_WIDTH-1:0] r_hit, n_hit;
    logic [LEN_W-1:0]       r_j, n_j;
    logic [SYM_W-1:0]       r_sym, n_sym;
    logic                   r_is_app, n_is_app;

    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    logic             w_go_walk;
    logic             w_eq;
    logic             w_walk_end;
    logic [LEN_W-1:0] w_j0;
    logic [LEN_W-1:0] w_jn;
    logic [LEN_W-1:0] w_jrd;
    logic [LEN_W-1:0] w_jrd_m1;

    assign w_accept   = i_start && (r_state == S_IDLE);
    assign w_full     = (r_len >= LEN_W'(MAX_PATTERN));
    assign w_empty    = (r_len == '0);
    assign w_go_walk  = !w_empty && (((i_req.req_type == REQ_APPEND) && !w_full)
                                     || (i_req.req_type == REQ_TEXT));
    assign w_j0       = (i_req.req_type == REQ_APPEND) ? r_bpl
                      : ((r_pos >= r_len) ? '0 : r_pos);
    assign w_eq       = (i_rd_pat == r_sym);
    assign w_walk_end = w_eq || (r_j == '0);
    assign w_jn       = w_eq ? (r_j + LEN_W'(1)) : '0;
    assign w_jrd      = (r_state == S_WALK) ? i_rd_fail : w_j0;
    assign w_jrd_m1   = w_jrd - LEN_W'(1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && w_go_walk) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (w_walk_end) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_len    = r_len;
        n_bpl    = r_bpl;
        n_pos    = r_pos;
        n_hit    = r_hit;
        n_j      = r_j;
        n_sym    = r_sym;
        n_is_app = r_is_app;
        o_done   = 1'b0;
        o_res.match_found = 1'b0;
        o_res.status      = ST_OK;
        o_mem.we         = 1'b0;
        o_mem.waddr      = r_len[IDX_W-1:0];
        o_mem.wpat       = r_sym;
        o_mem.wfail      = '0;
        o_mem.raddr_pat  = w_jrd[IDX_W-1:0];
        o_mem.raddr_fail = w_jrd_m1[IDX_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_sym    = i_req.symbol;
                    n_is_app = (i_req.req_type == REQ_APPEND);
                    n_j      = w_j0;
                    case (i_req.req_type)
                        REQ_CLEAR: begin
                            n_len  = '0;
                            n_bpl  = '0;
                            n_pos  = '0;
                            n_hit  = '0;
                            o_done = 1'b1;
                        end
                        REQ_APPEND: begin
                            if (w_full) begin
                                o_res.status = ST_FULL;
                                o_done       = 1'b1;
                            end else if (w_empty) begin
                                // first byte: failure entry is zero
                                o_mem.we   = 1'b1;
                                o_mem.wpat = i_req.symbol;
                                n_len      = LEN_W'(1);
                                n_bpl      = '0;
                                o_done     = 1'b1;
                            end
                        end
                        REQ_TEXT: begin
                            if (w_empty) begin
                                o_res.status = ST_EMPTY;
                                o_done       = 1'b1;
                            end
                        end
                        default: o_done = 1'b1;
                    endcase
                end
            end
            S_WALK: begin
                if (!w_walk_end) begin
                    n_j = i_rd_fail;
                end else begin
                    o_done = 1'b1;
                    if (r_is_app) begin
                        o_mem.we    = 1'b1;
                        o_mem.wfail = w_jn;
                        n_bpl       = w_jn;
                        n_len       = r_len + LEN_W'(1);
                    end else if (w_jn >= r_len) begin
                        // full occurrence, fall back along the last failure link
                        o_res.match_found = 1'b1;
                        if (r_hit != COUNT_MAX) begin
                            n_hit = r_hit + COUNT_WIDTH'(1);
                        end
                        n_pos = r_bpl;
                    end else begin
                        n_pos = w_jn;
                    end
                end
            end
            default: ;
        endcase
        o_res.match_count    = CNT_OUT_W'(n_hit);
        o_res.pattern_length = LEN_OUT_W'(n_len);
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_bpl   <= '0;
            r_pos   <= '0;
            r_hit   <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_bpl   <= n_bpl;
            r_pos   <= n_pos;
            r_hit   <= n_hit;
        end
        r_j      <= n_j;
        r_sym    <= n_sym;
        r_is_app <= n_is_app;
    end

    a_walk_in_pattern: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_j < r_len))
        else $error("failure walk index beyond pattern");

    a_prefix_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len != '0) |-> (r_bpl < r_len))
        else $error("build prefix not below pattern length");

    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= r_len)
        else $error("match position beyond pattern length");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (r_state == S_IDLE))
        else $error("engine still walking after result");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_accept && (i_req.req_type == REQ_CLEAR)) |=> (r_hit >= $past(r_hit)))
        else $error("hit count dropped without clear");

endmodule

`default_nettype wire

// ===== rtl/core/kmp_stream_matcher_core.sv =====
// ----------------------------------------------------------------------------
// kmp_stream_matcher_core
// Streaming Knuth-Morris-Pratt matcher: pattern and failure table in two
// synchronous RAMs, one failure-link step per cycle, registered result beat.
// ----------------------------------------------------------------------------
// result: clear, no-op, first append, full append and empty-pattern text give
//   the result beat in the cycle after start; others give it after a walk of
//   k compares (failure links followed plus one, one RAM read each)
// flow: busy high during the walk; start is accepted only while idle
// reset: synchronous active-low; pattern empty, count zero, RAM contents kept
// the result strobe lasts one cycle and cannot be held off by the receiver
`default_nettype none

module kmp_stream_matcher_core
    import kmp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_req i_req,
    output logic      busy,
    output logic      o_res_valid,
    output t_res      o_res
);

    t_mem_req         w_mem;
    logic [SYM_W-1:0] w_rd_pat;
    logic [LEN_W-1:0] w_rd_fail;
    logic             w_done;
    t_res             w_res;
    logic             r_res_valid;
    t_res             r_res;

    kmp_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_req     (i_req),
        .i_rd_pat  (w_rd_pat),
        .i_rd_fail (w_rd_fail),
        .o_busy    (busy),
        .o_done    (w_done),
        .o_res     (w_res),
        .o_mem     (w_mem)
    );

    kmp_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_PATTERN)
    ) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wpat),
        .i_raddr (w_mem.raddr_pat),
        .o_rdata (w_rd_pat)
    );

    kmp_ram #(
        .WIDTH (LEN_W),
        .DEPTH (MAX_PATTERN)
    ) u_fail_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wfail),
        .i_raddr (w_mem.raddr_fail),
        .o_rdata (w_rd_fail)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= w_done;
        end
        if (w_done) begin
            r_res <= w_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire
